### rtl/core/spq_pkg.sv
// Package for the sorted priority queue.
// Holds command and status codes and the cell data types; no dependencies.
package spq_pkg;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 16;
    localparam int COUNT_W = 5;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_REMOVED  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
    } t_cell_data;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctrl;

endpackage

### rtl/core/spq_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
module spq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  spq_pkg::t_cell_data i_new,
    input  spq_pkg::t_cell_data i_left,
    input  logic                i_left_kept,
    input  spq_pkg::t_cell_data i_right,
    output spq_pkg::t_cell_data o_data,
    output logic                o_kept
);

    logic                              r_valid;
    logic signed [spq_pkg::VALUE_W-1:0] r_value;
    logic signed [spq_pkg::PRIO_W-1:0]  r_prio;
    spq_pkg::t_cell_data               n_data;

    // entry stays put when it outranks or ties the new one
    assign o_kept = r_valid && ($signed(i_new.prio) <= r_prio);

    always_comb begin
        n_data = '{valid: r_valid, value: r_value, prio: r_prio};
        if (i_ctrl.ins) begin
            if (!o_kept) begin
                if (i_left_kept) begin
                    n_data = '{valid: 1'b1, value: i_new.value, prio: i_new.prio};
                end else begin
                    n_data = i_left;
                end
            end
        end else if (i_ctrl.rem) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_data.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_data.value;
        r_prio  <= n_data.prio;
    end

    assign o_data = '{valid: r_valid, value: r_value, prio: r_prio};

endmodule

### rtl/core/sorted_priority_queue.sv
// Sorted priority queue built as a chain of DEPTH slot cells.
// Depends on spq_pkg and spq_cell.
//
// One item (insert or remove) is taken in every clock cycle; busy stays low.
// All cells compare the new priority in parallel and shift together in the
// cycle the item is taken, so the result strobes in the cycle after
// start. Entries of equal priority leave in arrival order. A full insert is
// dropped with status full, an empty remove reports status empty; data
// fields are zero unless an entry was removed. The result cannot be stalled.
module sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cmd,
    input  logic signed [spq_pkg::VALUE_W-1:0]  i_item_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   i_item_priority,
    output logic                                o_strobe,
    output logic        [1:0]                   o_status,
    output logic signed [spq_pkg::VALUE_W-1:0]  o_out_value,
    output logic signed [spq_pkg::PRIO_W-1:0]   o_out_priority,
    output logic        [spq_pkg::COUNT_W-1:0]  o_entry_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    spq_pkg::t_cell_data cell_data [DEPTH];
    logic                cell_kept [DEPTH];
    spq_pkg::t_cell_ctrl ctrl;
    spq_pkg::t_cell_data new_data;

    logic              full;
    logic              empty;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_strobe;
    logic [1:0]        r_status;
    logic [1:0]        n_status;
    logic signed [spq_pkg::VALUE_W-1:0] r_value;
    logic signed [spq_pkg::VALUE_W-1:0] n_value;
    logic signed [spq_pkg::PRIO_W-1:0]  r_prio;
    logic signed [spq_pkg::PRIO_W-1:0]  n_prio;

    assign busy  = 1'b0;
    assign full  = cell_data[DEPTH-1].valid;
    assign empty = !cell_data[0].valid;

    assign ctrl.ins = start && (i_cmd == spq_pkg::CMD_INSERT) && !full;
    assign ctrl.rem = start && (i_cmd == spq_pkg::CMD_REMOVE) && !empty;
    assign new_data = '{valid: 1'b1, value: i_item_value, prio: i_item_priority};

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        spq_pkg::t_cell_data left;
        spq_pkg::t_cell_data right;
        logic                left_kept;

        if (g == 0) begin : g_first
            assign left      = '0;
            assign left_kept = 1'b1;
        end else begin : g_mid
            assign left      = cell_data[g-1];
            assign left_kept = cell_kept[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right = '0;
        end else begin : g_inner
            assign right = cell_data[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl),
            .i_new       (new_data),
            .i_left      (left),
            .i_left_kept (left_kept),
            .i_right     (right),
            .o_data      (cell_data[g]),
            .o_kept      (cell_kept[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = spq_pkg::ST_INSERTED;
        n_value  = '0;
        n_prio   = '0;
        case (i_cmd)
            spq_pkg::CMD_INSERT: begin
                if (full) begin
                    n_status = spq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            spq_pkg::CMD_REMOVE: begin
                if (empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end else begin
                    n_status = spq_pkg::ST_REMOVED;
                    n_value  = cell_data[0].value;
                    n_prio   = cell_data[0].prio;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= start;
            if (start) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_status <= n_status;
            r_value  <= n_value;
            r_prio   <= n_prio;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_out_value    = r_value;
    assign o_out_priority = r_prio;
    assign o_entry_count  = (32'(r_count) > 32'd31) ? spq_pkg::COUNT_W'(31)
                                                    : spq_pkg::COUNT_W'(r_count);

`ifndef SYNTHESIS
    a_strobe_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> o_strobe)
        else $error("result strobe missing after start");

    a_full_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full == (32'(r_count) == DEPTH))
        else $error("last cell valid disagrees with count");

    a_empty_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        empty == (r_count == '0))
        else $error("head cell valid disagrees with count");

    a_removed_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.rem |=> (o_status == spq_pkg::ST_REMOVED)
                     && (o_out_value == $past(cell_data[0].value)))
        else $error("removed item does not match old head");
`endif

endmodule

### bench/spq_checker.sv
// Checker for the sorted priority queue: predicts every result and compares it.
// Depends on spq_pkg; watches the command and result ports of the block.
`timescale 1ns / 1ps

module spq_checker #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic                                i_cmd,
    input  logic signed [spq_pkg::VALUE_W-1:0]  i_item_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   i_item_priority,
    input  logic                                i_strobe,
    input  logic        [1:0]                   i_status,
    input  logic signed [spq_pkg::VALUE_W-1:0]  i_out_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   i_out_priority,
    input  logic        [spq_pkg::COUNT_W-1:0]  i_entry_count,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    typedef struct packed {
        logic        [1:0]                  status;
        logic signed [spq_pkg::VALUE_W-1:0] value;
        logic signed [spq_pkg::PRIO_W-1:0]  prio;
        logic        [spq_pkg::COUNT_W-1:0] count;
    } t_outcome;

    logic signed [spq_pkg::VALUE_W-1:0] queued_value [DEPTH];
    logic signed [spq_pkg::PRIO_W-1:0]  queued_prio  [DEPTH];
    int                                 held;
    t_outcome                           pending_results [$];
    int                                 fails;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fails        = 0;
        held         = 0;
    end

    function automatic t_outcome apply_command(
        input logic                               cmd,
        input logic signed [spq_pkg::VALUE_W-1:0] val,
        input logic signed [spq_pkg::PRIO_W-1:0]  pri
    );
        t_outcome r;
        int pos;
        r = '0;
        if (cmd == spq_pkg::CMD_INSERT) begin
            if (held >= DEPTH) begin
                r.status = spq_pkg::ST_FULL;
            end else begin
                pos = 0;
                while (pos < held && pri <= queued_prio[pos])
                    pos++;
                for (int i = held; i > pos; i--) begin
                    queued_value[i] = queued_value[i-1];
                    queued_prio[i]  = queued_prio[i-1];
                end
                queued_value[pos] = val;
                queued_prio[pos]  = pri;
                held++;
                r.status = spq_pkg::ST_INSERTED;
            end
        end else begin
            if (held == 0) begin
                r.status = spq_pkg::ST_EMPTY;
            end else begin
                r.value = queued_value[0];
                r.prio  = queued_prio[0];
                for (int i = 0; i + 1 < held; i++) begin
                    queued_value[i] = queued_value[i+1];
                    queued_prio[i]  = queued_prio[i+1];
                end
                held--;
                r.status = spq_pkg::ST_REMOVED;
            end
        end
        r.count = (held > 31) ? 5'd31 : spq_pkg::COUNT_W'(held);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            held = 0;
            pending_results.delete();
        end else begin
            if (i_start && !i_busy)
                pending_results.push_back(
                    apply_command(i_cmd, i_item_value, i_item_priority));
            if (i_strobe) begin
                if (pending_results.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: result with no item outstanding: status %0d", $time,
                                 i_status);
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_status !== want.status || i_out_value !== want.value ||
                        i_out_priority !== want.prio || i_entry_count !== want.count) begin
                        if (fails < 10)
                            $display({"%0t: expected st %0d val %0d pri %0d cnt %0d, ",
                                      "got st %0d val %0d pri %0d cnt %0d"},
                                     $time, want.status, want.value, want.prio, want.count,
                                     i_status, i_out_value, i_out_priority, i_entry_count);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_results.size();
    end

endmodule

### bench/tb_sorted_priority_queue.sv
// Top of the sorted priority queue bench: clock, reset, command stimulus, verdict.
// Depends on spq_pkg, sorted_priority_queue and spq_checker.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

    localparam int DEPTH        = 16;
    localparam int IDLE_PCT     = 15;
    localparam int RANDOM_ITEMS = 1128;
    localparam int CYCLE_LIMIT  = 60000;

    logic                                i_clk           = 1'b0;
    logic                                i_rst_n         = 1'b0;
    logic                                start           = 1'b0;
    logic                                i_cmd           = spq_pkg::CMD_INSERT;
    logic signed [spq_pkg::VALUE_W-1:0]  i_item_value    = '0;
    logic signed [spq_pkg::PRIO_W-1:0]   i_item_priority = '0;
    logic                                busy;
    logic                                o_strobe;
    logic        [1:0]                   o_status;
    logic signed [spq_pkg::VALUE_W-1:0]  o_out_value;
    logic signed [spq_pkg::PRIO_W-1:0]   o_out_priority;
    logic        [spq_pkg::COUNT_W-1:0]  o_entry_count;
    int                                  fail_count;
    int                                  pending;
    int                                  cycles = 0;
    bit                                  quiet  = 1'b0;

    sorted_priority_queue #(.DEPTH(DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_item_value(i_item_value), .i_item_priority(i_item_priority),
        .o_strobe(o_strobe), .o_status(o_status), .o_out_value(o_out_value),
        .o_out_priority(o_out_priority), .o_entry_count(o_entry_count)
    );

    spq_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_cmd(i_cmd), .i_item_value(i_item_value), .i_item_priority(i_item_priority),
        .i_strobe(o_strobe), .i_status(o_status), .i_out_value(o_out_value),
        .i_out_priority(o_out_priority), .i_entry_count(o_entry_count),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("sorted_priority_queue: mismatch");
            $finish;
        end
    end

    task automatic send_item(input logic cmd,
                             input logic signed [spq_pkg::VALUE_W-1:0] val,
                             input logic signed [spq_pkg::PRIO_W-1:0] pri);
        int gap;
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_cmd           <= cmd;
        i_item_value    <= val;
        i_item_priority <= pri;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic signed [spq_pkg::PRIO_W-1:0] pick_priority();
        case ($urandom_range(0, 3))
            0:       return spq_pkg::PRIO_W'($urandom);
            1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return spq_pkg::PRIO_W'(int'($urandom_range(0, 8)) - 4);
        endcase
    endfunction

    initial begin
        int ins_pct;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty remove, extremes, ties at top, bottom and middle, full store
        send_item(spq_pkg::CMD_REMOVE, 32'sd77, 16'sd5);
        send_item(spq_pkg::CMD_INSERT, 32'sh7FFFFFFF, 16'sh7FFF);
        send_item(spq_pkg::CMD_INSERT, 32'sh80000000, 16'sh8000);
        send_item(spq_pkg::CMD_INSERT, 32'sd0, 16'sd0);
        send_item(spq_pkg::CMD_INSERT, 32'sd1, 16'sd0);
        send_item(spq_pkg::CMD_INSERT, -32'sd1, 16'sd0);
        send_item(spq_pkg::CMD_INSERT, 32'sd5, 16'sh7FFF);
        send_item(spq_pkg::CMD_INSERT, 32'sd6, 16'sh8000);
        send_item(spq_pkg::CMD_INSERT, 32'shAAAAAAAA, 16'sh5555);
        send_item(spq_pkg::CMD_INSERT, 32'sh55555555, 16'shAAAA);
        send_item(spq_pkg::CMD_INSERT, 32'sd10, 16'sd100);
        send_item(spq_pkg::CMD_INSERT, 32'sd11, -16'sd100);
        send_item(spq_pkg::CMD_INSERT, 32'sd12, 16'sd100);
        send_item(spq_pkg::CMD_INSERT, 32'sd13, 16'sd1);
        send_item(spq_pkg::CMD_INSERT, 32'sd14, -16'sd1);
        send_item(spq_pkg::CMD_INSERT, 32'sd15, 16'sd0);
        send_item(spq_pkg::CMD_INSERT, 32'sd16, 16'sh7FFE);
        send_item(spq_pkg::CMD_INSERT, 32'sd99, 16'sh7FFF);
        repeat (4) send_item(spq_pkg::CMD_REMOVE, 32'hFFFFFFFF, 16'hFFFF);

        ins_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) begin
                case ((n / 64) % 6)
                    0: ins_pct = 90;
                    1: ins_pct = 15;
                    2: ins_pct = 60;
                    3: ins_pct = 95;
                    4: ins_pct = 40;
                    default: ins_pct = 8;
                endcase
            end
            quiet = (n >= 400 && n < 700);
            send_item(($urandom_range(0, 99) < ins_pct) ? spq_pkg::CMD_INSERT
                                                        : spq_pkg::CMD_REMOVE,
                      spq_pkg::VALUE_W'($urandom), pick_priority());
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("sorted_priority_queue: match");
        end else begin
            $display("sorted_priority_queue: mismatch");
        end
        $finish;
    end

endmodule
